FILE: rtl/assert_macros.svh
// assertion macros used by the checker file mpfla_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MPFLA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mpfla_pkg.sv
// shared constants, types and codes of the multi-pool free list allocator
// no dependencies
package mpfla_pkg;

  localparam int MAX_POOLS  = 4;
  localparam int POOL_DEPTH = 1024;

  localparam int POOL_W = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int SLOT_W = $clog2(POOL_DEPTH);
  localparam int HEAD_W = SLOT_W + 1;
  localparam int ACT_W  = $clog2(MAX_POOLS + 1);
  localparam int ADDR_W = POOL_W + SLOT_W;
  localparam int LINK_DEPTH = 1 << ADDR_W;

  localparam int CFG_W  = 11;
  localparam int SIZE_W = (HEAD_W > CFG_W) ? HEAD_W : CFG_W;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;
  localparam int STAT_W = 2;

  localparam logic [PADDR_W-1:0] ADDR_POOL_BLOCKS  = '0;
  localparam logic [CFG_W-1:0]   POOL_BLOCKS_RESET = 11'd1024;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADFREE = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [HEAD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } link_req_t;

endpackage

FILE: rtl/mpfla_link_ram.sv
// link memory: one write port and one registered read port
// depends on mpfla_pkg
module mpfla_link_ram (
  input  logic                          clk,
  input  mpfla_pkg::link_req_t          req,
  output logic [mpfla_pkg::HEAD_W-1:0]  rdata
);

  logic [mpfla_pkg::HEAD_W-1:0] mem [mpfla_pkg::LINK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/multi_pool_free_list_allocator_unit.sv
// top level of the multi-pool free list allocator: pool heads, control, result register
// depends on mpfla_pkg and mpfla_link_ram
//
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall  | action, free_pool, free_slot
//  out_     | output    | out_valid/out_stall| status, given_pool, given_slot
//  cfg      | apb write | psel/penable/pready| pool_blocks at byte address 0
//
// an allocate reads the link memory, then writes the pool head back and loads the result
// a free or an error is handled in ST_IDLE alone and loads the result directly
// after reset a clearing pass fills the whole link memory; in_stall stays high
// in_stall is also high while a result is held by out_stall
module multi_pool_free_list_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [mpfla_pkg::POOL_W-1:0]      in_free_pool,
  input  logic [mpfla_pkg::SLOT_W-1:0]      in_free_slot,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mpfla_pkg::STAT_W-1:0]      out_status,
  output logic [mpfla_pkg::POOL_W-1:0]      out_given_pool,
  output logic [mpfla_pkg::SLOT_W-1:0]      out_given_slot,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mpfla_pkg::PADDR_W-1:0]     paddr,
  input  logic [mpfla_pkg::DATA_W-1:0]      pwdata,
  output logic [mpfla_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  mpfla_pkg::state_t state_r, state_nxt;

  logic [mpfla_pkg::CFG_W-1:0]  pool_blocks_r;
  logic [mpfla_pkg::ADDR_W-1:0] clr_cnt_r;
  logic [mpfla_pkg::HEAD_W-1:0] head_r [mpfla_pkg::MAX_POOLS];
  logic [mpfla_pkg::ACT_W-1:0]  active_r;
  logic [mpfla_pkg::POOL_W-1:0] alloc_p_r;
  logic [mpfla_pkg::SLOT_W-1:0] alloc_slot_r;

  logic                         out_valid_r;
  logic [mpfla_pkg::STAT_W-1:0] out_status_r;
  logic [mpfla_pkg::POOL_W-1:0] out_pool_r;
  logic [mpfla_pkg::SLOT_W-1:0] out_slot_r;

  logic [mpfla_pkg::SIZE_W-1:0] eff_size;
  logic [mpfla_pkg::MAX_POOLS-1:0] full;
  logic                         found;
  logic [mpfla_pkg::POOL_W-1:0] first_p;
  logic [mpfla_pkg::POOL_W-1:0] grow_p;
  logic [mpfla_pkg::POOL_W-1:0] alloc_p;
  logic                         can_grow;
  logic                         alloc_ok;
  logic                         grow;
  logic                         free_bad;
  logic [mpfla_pkg::POOL_W-1:0] hd_p;
  logic [mpfla_pkg::HEAD_W-1:0] hd_val;
  logic                         accept;
  logic                         cfg_wr;

  mpfla_pkg::link_req_t         req;
  logic [mpfla_pkg::HEAD_W-1:0] rdata;

  logic                         head_we;
  logic [mpfla_pkg::POOL_W-1:0] head_wp;
  logic [mpfla_pkg::HEAD_W-1:0] head_wd;
  logic                         alloc_start;
  logic                         ld;
  logic [mpfla_pkg::STAT_W-1:0] ld_status;
  logic [mpfla_pkg::POOL_W-1:0] ld_pool;
  logic [mpfla_pkg::SLOT_W-1:0] ld_slot;

  mpfla_link_ram u_link_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == mpfla_pkg::ADDR_POOL_BLOCKS);
  assign prdata = (paddr == mpfla_pkg::ADDR_POOL_BLOCKS) ?
                  mpfla_pkg::DATA_W'(pool_blocks_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_blocks_r <= mpfla_pkg::POOL_BLOCKS_RESET;
    end else if (cfg_wr) begin
      pool_blocks_r <= pwdata[mpfla_pkg::CFG_W-1:0];
    end
  end

  // pool selection
  assign eff_size = (mpfla_pkg::SIZE_W'(pool_blocks_r) > mpfla_pkg::SIZE_W'(mpfla_pkg::POOL_DEPTH)) ?
                    mpfla_pkg::SIZE_W'(mpfla_pkg::POOL_DEPTH) :
                    mpfla_pkg::SIZE_W'(pool_blocks_r);

  always_comb begin
    found   = 1'b0;
    first_p = '0;
    for (int p = 0; p < mpfla_pkg::MAX_POOLS; p++) begin
      full[p] = mpfla_pkg::SIZE_W'(head_r[p]) >= eff_size;
      if (!found && (mpfla_pkg::ACT_W'(p) < active_r) && !full[p]) begin
        found   = 1'b1;
        first_p = mpfla_pkg::POOL_W'(p);
      end
    end
  end

  assign can_grow = active_r < mpfla_pkg::ACT_W'(mpfla_pkg::MAX_POOLS);
  assign grow_p   = active_r[mpfla_pkg::POOL_W-1:0];
  assign alloc_p  = found ? first_p : grow_p;
  assign grow     = (eff_size != '0) && !found && can_grow;
  assign alloc_ok = (eff_size != '0) && (found || (can_grow && !full[grow_p]));
  assign free_bad = (mpfla_pkg::ACT_W'(in_free_pool) >= active_r) ||
                    (mpfla_pkg::SIZE_W'(in_free_slot) >= eff_size);

  assign hd_p   = in_action ? in_free_pool : alloc_p;
  assign hd_val = head_r[hd_p];

  assign in_stall = (state_r != mpfla_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpfla_pkg::ST_CLEAR: begin
        if (&clr_cnt_r) begin
          state_nxt = mpfla_pkg::ST_IDLE;
        end
      end
      mpfla_pkg::ST_IDLE: begin
        if (accept && !in_action && alloc_ok) begin
          state_nxt = mpfla_pkg::ST_ALLOC;
        end
      end
      mpfla_pkg::ST_ALLOC: state_nxt = mpfla_pkg::ST_IDLE;
      default:             state_nxt = mpfla_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req         = '0;
    head_we     = 1'b0;
    head_wp     = alloc_p_r;
    head_wd     = rdata;
    alloc_start = 1'b0;
    ld          = 1'b0;
    ld_status   = mpfla_pkg::STAT_OK;
    ld_pool     = '0;
    ld_slot     = '0;
    case (state_r)
      mpfla_pkg::ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_cnt_r;
        req.wdata = mpfla_pkg::HEAD_W'(clr_cnt_r[mpfla_pkg::SLOT_W-1:0]) + mpfla_pkg::HEAD_W'(1);
      end
      mpfla_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_action) begin
            if (alloc_ok) begin
              req.re      = 1'b1;
              req.raddr   = {alloc_p, hd_val[mpfla_pkg::SLOT_W-1:0]};
              alloc_start = 1'b1;
            end else begin
              ld        = 1'b1;
              ld_status = mpfla_pkg::STAT_NOMEM;
            end
          end else if (free_bad) begin
            ld        = 1'b1;
            ld_status = mpfla_pkg::STAT_BADFREE;
          end else begin
            req.we    = 1'b1;
            req.waddr = {in_free_pool, in_free_slot};
            req.wdata = hd_val;
            head_we   = 1'b1;
            head_wp   = in_free_pool;
            head_wd   = mpfla_pkg::HEAD_W'(in_free_slot);
            ld        = 1'b1;
          end
        end
      end
      mpfla_pkg::ST_ALLOC: begin
        head_we = 1'b1;
        ld      = 1'b1;
        ld_pool = alloc_p_r;
        ld_slot = alloc_slot_r;
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mpfla_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      active_r  <= mpfla_pkg::ACT_W'(1);
      for (int p = 0; p < mpfla_pkg::MAX_POOLS; p++) begin
        head_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == mpfla_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + mpfla_pkg::ADDR_W'(1);
      end
      if (accept && !in_action && grow) begin
        active_r <= active_r + mpfla_pkg::ACT_W'(1);
      end
      if (head_we) begin
        head_r[head_wp] <= head_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_start) begin
      alloc_p_r    <= alloc_p;
      alloc_slot_r <= hd_val[mpfla_pkg::SLOT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ld || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status_r <= ld_status;
      out_pool_r   <= ld_pool;
      out_slot_r   <= ld_slot;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_given_pool = out_pool_r;
  assign out_given_slot = out_slot_r;

endmodule

FILE: rtl/mpfla_checker.sv
// port-level checks of the allocator, attached by bind
// depends on mpfla_pkg and assert_macros.svh
`include "assert_macros.svh"

module mpfla_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_action,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mpfla_pkg::STAT_W-1:0]  out_status,
  input logic [mpfla_pkg::POOL_W-1:0]  out_given_pool,
  input logic [mpfla_pkg::SLOT_W-1:0]  out_given_slot
);

  `MPFLA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_given_pool) && $stable(out_given_slot), "stalled result changed")
  `MPFLA_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (out_status != mpfla_pkg::STAT_OK), (out_given_pool == '0) && (out_given_slot == '0), "error result carries a handle")
  `MPFLA_ASSERT_NEXT(a_free_result, clk, rst_n, in_valid && !in_stall && in_action, out_valid, "free transfer gave no result")
  `MPFLA_ASSERT_NOW(a_held_stall, clk, rst_n, out_valid && out_stall, in_stall, "input taken while result held")

endmodule

bind multi_pool_free_list_allocator_unit mpfla_checker u_mpfla_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_action      (in_action),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_given_pool (out_given_pool),
  .out_given_slot (out_given_slot)
);
